### src/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// shared constants and types of the bilinear rgba scaler
// ----------------------------------------------------------------------------
package brs_pkg;

   localparam int MAX_SOURCE_SIDE_DEF = 256;
   localparam int MAX_TARGET_SIDE_DEF = 4096;
   localparam int FRACTION_BITS_DEF   = 16;

   localparam int SRC_REG_W   = 9;
   localparam int TGT_REG_W   = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int COORD_W     = 8;
   localparam int SAMPLE_W    = 12;
   localparam int PIXEL_W     = 32;
   localparam int CHAN_W      = 8;
   localparam int CHANNELS    = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_RD1  = 4'b0010,
      SEQ_RD2  = 4'b0100,
      SEQ_RD3  = 4'b1000
   } seq_state_type;

endpackage

### src/brs_ram.sv
// ----------------------------------------------------------------------------
// brs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bilinear_rgba_scaler.sv
// ----------------------------------------------------------------------------
// bilinear_rgba_scaler
// stores a source rgba image and returns bilinear samples of a scaled image
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   req_type, req_load_*, req_*    start / busy
//  response  rsp_scaled_pixel               rsp_valid strobe, no stall
//  config    csr_index, csr_write_data      csr_write_enable
//
//  a load uses the image memory port once, a sample reads it four times (one read
//  per neighbor); a new sample waits for the reads of the last one, and loads go
//  one per cycle while no sample is being read. NW = 13 + clog2(src+1) + fraction
//  bits is the quotient width of the bit-per-stage coordinate divider.
//  reset clears control state only; the image memory is not cleared.
//  busy rises while the divider output waits for the memory sequencer.
// ----------------------------------------------------------------------------
module bilinear_rgba_scaler #(
   parameter int MAX_SOURCE_SIDE = brs_pkg::MAX_SOURCE_SIDE_DEF,
   parameter int MAX_TARGET_SIDE = brs_pkg::MAX_TARGET_SIDE_DEF,
   parameter int FRACTION_BITS   = brs_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [brs_pkg::COORD_W-1:0]       req_load_x,
   input  logic [brs_pkg::COORD_W-1:0]       req_load_y,
   input  logic [brs_pkg::PIXEL_W-1:0]       req_load_pixel,
   input  logic [brs_pkg::SAMPLE_W-1:0]      req_sample_x,
   input  logic [brs_pkg::SAMPLE_W-1:0]      req_sample_y,
   output logic                              rsp_valid,
   output logic [brs_pkg::PIXEL_W-1:0]       rsp_scaled_pixel,
   input  logic                              csr_write_enable,
   input  logic [brs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int F     = FRACTION_BITS;
   localparam int SRC_W = $clog2(MAX_SOURCE_SIDE + 1);
   localparam int TGT_W = $clog2(MAX_TARGET_SIDE + 1);
   localparam int IW    = $clog2(MAX_SOURCE_SIDE);
   localparam int DEPTH = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = brs_pkg::SAMPLE_W + 1;
   localparam int MW    = OW + SRC_W;
   localparam int NW    = MW + F;
   localparam int CW    = NW - F;
   localparam int DW    = TGT_W + 1;
   localparam int TW    = F + brs_pkg::CHAN_W + 1;
   localparam int VW    = TW + F + 1;
   localparam int HW    = VW + 1 - 2 * F;
   localparam logic [F:0]    ONE_FX  = (F + 1)'(1) << F;
   localparam logic [NW-1:0] HALF_FX = NW'(1) << (F - 1);

   typedef struct packed {
      logic [IW-1:0] i0;
      logic [IW-1:0] i1;
      logic [F-1:0]  f;
   } axis_type;

   function automatic axis_type axis_map(input logic [NW-1:0] t,
                                         input logic [SRC_W-1:0] src);
      logic [NW-1:0] s;
      logic [CW-1:0] ip;
      logic [CW-1:0] lim;
      logic [CW-1:0] nx;
      axis_type      r;
      s   = t - HALF_FX;
      ip  = '0;
      r.f = '0;
      if (t >= HALF_FX) begin
         ip  = s[NW-1:F];
         r.f = s[F-1:0];
      end
      lim = CW'(src) - CW'(1);
      if (ip > lim) begin
         ip = lim;
      end
      nx   = ip + CW'(1);
      r.i0 = IW'(ip);
      r.i1 = (nx < CW'(src)) ? IW'(nx) : IW'(lim);
      return r;
   endfunction

   function automatic logic [AW-1:0] pix_addr(input logic [IW-1:0] x,
                                              input logic [IW-1:0] y);
      return AW'(32'(y) * 32'(MAX_SOURCE_SIDE) + 32'(x));
   endfunction

   // configuration
   logic [brs_pkg::SRC_REG_W-1:0] src_w_ff, src_h_ff;
   logic [brs_pkg::TGT_REG_W-1:0] tgt_w_ff, tgt_h_ff;
   logic [SRC_W-1:0] sw_ff, sh_ff, sw_in, sh_in;
   logic [TGT_W-1:0] tw_ff, th_ff, tw_in, th_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= brs_pkg::SRC_REG_W'(1);
         src_h_ff <= brs_pkg::SRC_REG_W'(1);
         tgt_w_ff <= brs_pkg::TGT_REG_W'(1);
         tgt_h_ff <= brs_pkg::TGT_REG_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            brs_pkg::REG_SOURCE_WIDTH:
               src_w_ff <= csr_write_data[brs_pkg::SRC_REG_W-1:0];
            brs_pkg::REG_SOURCE_HEIGHT:
               src_h_ff <= csr_write_data[brs_pkg::SRC_REG_W-1:0];
            brs_pkg::REG_TARGET_WIDTH:
               tgt_w_ff <= csr_write_data;
            brs_pkg::REG_TARGET_HEIGHT:
               tgt_h_ff <= csr_write_data;
         endcase
      end
   end

   always_comb begin
      sw_in = (src_w_ff == '0) ? SRC_W'(1) :
              (32'(src_w_ff) > 32'(MAX_SOURCE_SIDE)) ? SRC_W'(MAX_SOURCE_SIDE) :
              SRC_W'(src_w_ff);
      sh_in = (src_h_ff == '0) ? SRC_W'(1) :
              (32'(src_h_ff) > 32'(MAX_SOURCE_SIDE)) ? SRC_W'(MAX_SOURCE_SIDE) :
              SRC_W'(src_h_ff);
      tw_in = (tgt_w_ff == '0) ? TGT_W'(1) :
              (32'(tgt_w_ff) > 32'(MAX_TARGET_SIDE)) ? TGT_W'(MAX_TARGET_SIDE) :
              TGT_W'(tgt_w_ff);
      th_in = (tgt_h_ff == '0) ? TGT_W'(1) :
              (32'(tgt_h_ff) > 32'(MAX_TARGET_SIDE)) ? TGT_W'(MAX_TARGET_SIDE) :
              TGT_W'(tgt_h_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= SRC_W'(1);
         sh_ff <= SRC_W'(1);
         tw_ff <= TGT_W'(1);
         th_ff <= TGT_W'(1);
      end else begin
         sw_ff <= sw_in;
         sh_ff <= sh_in;
         tw_ff <= tw_in;
         th_ff <= th_in;
      end
   end

   // coordinate divider pipeline
   logic                          vld_ff [0:NW];
   logic                          typ_ff [0:NW];
   logic [brs_pkg::COORD_W-1:0]   lx_ff  [0:NW];
   logic [brs_pkg::COORD_W-1:0]   ly_ff  [0:NW];
   logic [brs_pkg::PIXEL_W-1:0]   pix_ff [0:NW];
   logic [NW-1:0]                 nqx_ff [0:NW];
   logic [NW-1:0]                 nqy_ff [0:NW];
   logic [DW-1:0]                 remx_ff [0:NW];
   logic [DW-1:0]                 remy_ff [0:NW];
   logic [DW-1:0]                 dvx, dvy;
   logic                          adv, take, accept;

   assign dvx    = {tw_ff, 1'b0};
   assign dvy    = {th_ff, 1'b0};
   assign accept = start & adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         typ_ff[0]  <= req_type;
         lx_ff[0]   <= req_load_x;
         ly_ff[0]   <= req_load_y;
         pix_ff[0]  <= req_load_pixel;
         nqx_ff[0]  <= {MW'({req_sample_x, 1'b1}) * MW'(sw_ff), F'(0)};
         nqy_ff[0]  <= {MW'({req_sample_y, 1'b1}) * MW'(sh_ff), F'(0)};
         remx_ff[0] <= '0;
         remy_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= NW; k++) begin : g_div
      logic [DW:0] rx2, ry2;
      logic        gx, gy;

      assign rx2 = {remx_ff[k-1], nqx_ff[k-1][NW-1]};
      assign ry2 = {remy_ff[k-1], nqy_ff[k-1][NW-1]};
      assign gx  = rx2 >= {1'b0, dvx};
      assign gy  = ry2 >= {1'b0, dvy};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            typ_ff[k]  <= typ_ff[k-1];
            lx_ff[k]   <= lx_ff[k-1];
            ly_ff[k]   <= ly_ff[k-1];
            pix_ff[k]  <= pix_ff[k-1];
            nqx_ff[k]  <= {nqx_ff[k-1][NW-2:0], gx};
            nqy_ff[k]  <= {nqy_ff[k-1][NW-2:0], gy};
            remx_ff[k] <= gx ? DW'(rx2 - {1'b0, dvx}) : DW'(rx2);
            remy_ff[k] <= gy ? DW'(ry2 - {1'b0, dvy}) : DW'(ry2);
         end
      end
   end

   // memory sequencer
   brs_pkg::seq_state_type state_ff, state_in;
   axis_type               ax, ay;
   logic [IW-1:0]          x0_ff, x1_ff, y0_ff, y1_ff;
   logic [F-1:0]           fx_ff, fy_ff;
   logic                   is_sample, is_load, in_range;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [brs_pkg::PIXEL_W-1:0] rd_data;
   logic [3:0]             tag_in, tag_ff;

   assign ax        = axis_map(nqx_ff[NW], sw_ff);
   assign ay        = axis_map(nqy_ff[NW], sh_ff);
   assign take      = (state_ff == brs_pkg::SEQ_IDLE) & vld_ff[NW];
   assign adv       = ~vld_ff[NW] | take;
   assign busy      = ~adv;
   assign is_sample = take & (typ_ff[NW] == brs_pkg::REQ_SAMPLE);
   assign is_load   = take & (typ_ff[NW] == brs_pkg::REQ_LOAD);
   assign in_range  = (32'(lx_ff[NW]) < 32'(MAX_SOURCE_SIDE)) &
                      (32'(ly_ff[NW]) < 32'(MAX_SOURCE_SIDE));
   assign wr_en     = is_load & in_range;
   assign wr_addr   = AW'(32'(ly_ff[NW]) * 32'(MAX_SOURCE_SIDE) + 32'(lx_ff[NW]));

   always_comb begin
      state_in = state_ff;
      rd_addr  = pix_addr(ax.i0, ay.i0);
      tag_in   = '0;
      unique case (state_ff)
         brs_pkg::SEQ_IDLE: begin
            if (is_sample) begin
               state_in  = brs_pkg::SEQ_RD1;
               tag_in[0] = 1'b1;
            end
         end
         brs_pkg::SEQ_RD1: begin
            rd_addr   = pix_addr(x1_ff, y0_ff);
            tag_in[1] = 1'b1;
            state_in  = brs_pkg::SEQ_RD2;
         end
         brs_pkg::SEQ_RD2: begin
            rd_addr   = pix_addr(x0_ff, y1_ff);
            tag_in[2] = 1'b1;
            state_in  = brs_pkg::SEQ_RD3;
         end
         brs_pkg::SEQ_RD3: begin
            rd_addr   = pix_addr(x1_ff, y1_ff);
            tag_in[3] = 1'b1;
            state_in  = brs_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = brs_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brs_pkg::SEQ_IDLE;
         tag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_sample) begin
         x0_ff <= ax.i0;
         x1_ff <= ax.i1;
         y0_ff <= ay.i0;
         y1_ff <= ay.i1;
         fx_ff <= ax.f;
         fy_ff <= ay.f;
      end
   end

   brs_ram #(
      .WIDTH (brs_pkg::PIXEL_W),
      .DEPTH (DEPTH)
   ) u_image (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (pix_ff[NW]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // blend datapath
   logic [brs_pkg::PIXEL_W-1:0] hold_ff;
   logic [TW-1:0]               top_ff [brs_pkg::CHANNELS];
   logic [TW-1:0]               bot_ff [brs_pkg::CHANNELS];
   logic [VW-1:0]               v_ff   [brs_pkg::CHANNELS];
   logic [F-1:0]                vfy_ff;
   logic                        vv_ff, fin_ff, rsp_valid_ff;
   logic [brs_pkg::PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic [F:0]                  wx0, wy0;

   assign wx0 = ONE_FX - (F + 1)'(fx_ff);
   assign wy0 = ONE_FX - (F + 1)'(vfy_ff);

   always_ff @(posedge clock) begin
      if (tag_ff[0] | tag_ff[2]) begin
         hold_ff <= rd_data;
      end
      if (tag_ff[3]) begin
         vfy_ff <= fy_ff;
      end
   end

   for (genvar c = 0; c < brs_pkg::CHANNELS; c++) begin : g_chan
      logic [TW-1:0] hm;
      logic [VW-1:0] vm;
      logic [VW:0]   rnd;
      logic [HW-1:0] hi;

      assign hm  = TW'(hold_ff[c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W]) * TW'(wx0) +
                   TW'(rd_data[c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W]) * TW'(fx_ff);
      assign vm  = VW'(top_ff[c]) * VW'(wy0) + VW'(bot_ff[c]) * VW'(vfy_ff);
      assign rnd = {1'b0, v_ff[c]} + ((VW + 1)'(1) << (2 * F - 1));
      assign hi  = rnd[VW:2*F];
      assign rsp_pixel_in[c*brs_pkg::CHAN_W +: brs_pkg::CHAN_W] =
         (|hi[HW-1:brs_pkg::CHAN_W]) ? {brs_pkg::CHAN_W{1'b1}} :
                                       hi[brs_pkg::CHAN_W-1:0];

      always_ff @(posedge clock) begin
         if (tag_ff[1]) begin
            top_ff[c] <= hm;
         end
         if (tag_ff[3]) begin
            bot_ff[c] <= hm;
         end
         if (vv_ff) begin
            v_ff[c] <= vm;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff        <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vv_ff        <= tag_ff[3];
         fin_ff       <= vv_ff;
         rsp_valid_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_pixel = rsp_pixel_ff;

endmodule

### src/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// port level checks of the bilinear rgba scaler
// ----------------------------------------------------------------------------
module brs_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid
);

   a_rsp_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !busy)
      else $error("busy right after reset");

   a_rsp_gap_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses in adjacent cycles");

   a_rsp_gap_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> ##1 !rsp_valid)
      else $error("responses closer than the read sequence allows");

endmodule

bind bilinear_rgba_scaler brs_checker u_brs_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

### verif/bilinear_rgba_scaler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_rgba_scaler_tb
// checks the scaler against a fixed-point bilinear predictor: source pixels
// are loaded ahead of every sample that reads them, sizes change between
// phases once the block has drained, and each scaled pixel is compared with
// the oldest expected one
// ----------------------------------------------------------------------------
module bilinear_rgba_scaler_tb;

   localparam int FB          = brs_pkg::FRACTION_BITS_DEF;
   localparam int SRC_SIDE    = brs_pkg::MAX_SOURCE_SIDE_DEF;
   localparam int TGT_SIDE    = brs_pkg::MAX_TARGET_SIDE_DEF;
   localparam int COORD_W     = brs_pkg::COORD_W;
   localparam int SAMPLE_W    = brs_pkg::SAMPLE_W;
   localparam int PIXEL_W     = brs_pkg::PIXEL_W;
   localparam int CHAN_W      = brs_pkg::CHAN_W;
   localparam int SRC_REG_W   = brs_pkg::SRC_REG_W;
   localparam int TGT_REG_W   = brs_pkg::TGT_REG_W;
   localparam int CSR_DATA_W  = brs_pkg::CSR_DATA_W;
   localparam int CSR_INDEX_W = brs_pkg::CSR_INDEX_W;
   localparam int SETTLE      = 80;
   localparam int WATCH_MAX   = 4000;
   localparam int PHASE_ITEMS = 170;

   typedef struct {
      logic                kind;
      logic [COORD_W-1:0]  lx;
      logic [COORD_W-1:0]  ly;
      logic [PIXEL_W-1:0]  pixel;
      logic [SAMPLE_W-1:0] sx;
      logic [SAMPLE_W-1:0] sy;
   } scaler_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = brs_pkg::REQ_LOAD;
   logic [COORD_W-1:0] req_load_x = '0;
   logic [COORD_W-1:0] req_load_y = '0;
   logic [PIXEL_W-1:0] req_load_pixel = '0;
   logic [SAMPLE_W-1:0] req_sample_x = '0;
   logic [SAMPLE_W-1:0] req_sample_y = '0;
   logic rsp_valid;
   logic [PIXEL_W-1:0] rsp_scaled_pixel;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = brs_pkg::REG_SOURCE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   bilinear_rgba_scaler dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   scaler_req_type pending_q[$];
   logic [PIXEL_W-1:0] pixel_expect_q[$];
   logic [PIXEL_W-1:0] image_model[SRC_SIDE*SRC_SIDE];
   bit written_map[SRC_SIDE*SRC_SIDE];
   logic [SRC_REG_W-1:0] model_sw = 1, model_sh = 1;
   logic [TGT_REG_W-1:0] model_tw = 1, model_th = 1;
   int gen_sw = 1, gen_sh = 1, gen_tw = 1, gen_th = 1;
   int idle_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int queued_items = 0;
   logic taken = 1'b0;

   function automatic int eff_size(int v, int limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
   endfunction

   function automatic void axis_neighbors(input int o, input int src, input int tgt,
                                          output int i0, output int i1,
                                          output longint unsigned frac);
      longint unsigned num, t, s, ip;
      num = (longint'(2 * o + 1) * src) << FB;
      t = num / (2 * longint'(tgt));
      ip = 0;
      frac = 0;
      if (t >= (64'd1 << (FB - 1))) begin
         s = t - (64'd1 << (FB - 1));
         ip = s >> FB;
         frac = s & ((64'd1 << FB) - 1);
      end
      if (ip > 64'(src - 1)) ip = 64'(src - 1);
      i0 = int'(ip);
      i1 = (i0 + 1 < src) ? i0 + 1 : src - 1;
   endfunction

   function automatic logic [PIXEL_W-1:0] blend_pixel(int ox, int oy);
      int x0, x1, y0, y1;
      longint unsigned fx, fy, one, a, b, d, e, top, bot, v, ch;
      logic [PIXEL_W-1:0] p00, p10, p01, p11, res;
      one = 64'd1 << FB;
      axis_neighbors(ox, eff_size(int'(model_sw), SRC_SIDE),
                     eff_size(int'(model_tw), TGT_SIDE), x0, x1, fx);
      axis_neighbors(oy, eff_size(int'(model_sh), SRC_SIDE),
                     eff_size(int'(model_th), TGT_SIDE), y0, y1, fy);
      p00 = image_model[y0*SRC_SIDE + x0];
      p10 = image_model[y0*SRC_SIDE + x1];
      p01 = image_model[y1*SRC_SIDE + x0];
      p11 = image_model[y1*SRC_SIDE + x1];
      res = '0;
      for (int c = 0; c < brs_pkg::CHANNELS; c++) begin
         a = 64'(p00[c*CHAN_W +: CHAN_W]);
         b = 64'(p10[c*CHAN_W +: CHAN_W]);
         d = 64'(p01[c*CHAN_W +: CHAN_W]);
         e = 64'(p11[c*CHAN_W +: CHAN_W]);
         top = a * (one - fx) + b * fx;
         bot = d * (one - fx) + e * fx;
         v = top * (one - fy) + bot * fy;
         ch = (v + (64'd1 << (2*FB - 1))) >> (2*FB);
         if (ch > 255) ch = 255;
         res[c*CHAN_W +: CHAN_W] = ch[CHAN_W-1:0];
      end
      return res;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            scaler_req_type r;
            r = pending_q.pop_front();
            req_type       <= r.kind;
            req_load_x     <= r.lx;
            req_load_y     <= r.ly;
            req_load_pixel <= r.pixel;
            req_sample_x   <= r.sx;
            req_sample_y   <= r.sy;
            start          <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      logic [PIXEL_W-1:0] want;
      if (reset) begin
         taken <= 1'b0;
      end else begin
         taken <= start && !busy;
         if (csr_write_enable) begin
            case (csr_index)
               brs_pkg::REG_SOURCE_WIDTH:  model_sw = csr_write_data[SRC_REG_W-1:0];
               brs_pkg::REG_SOURCE_HEIGHT: model_sh = csr_write_data[SRC_REG_W-1:0];
               brs_pkg::REG_TARGET_WIDTH:  model_tw = csr_write_data[TGT_REG_W-1:0];
               brs_pkg::REG_TARGET_HEIGHT: model_th = csr_write_data[TGT_REG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (pixel_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: scaled_pixel %h", rsp_scaled_pixel);
            end else begin
               want = pixel_expect_q.pop_front();
               if (rsp_scaled_pixel !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("scaled_pixel mismatch: expected %h actual %h",
                              want, rsp_scaled_pixel);
               end
            end
         end
         if (start && !busy) begin
            if (req_type == brs_pkg::REQ_LOAD)
               image_model[req_load_y*SRC_SIDE + req_load_x] = req_load_pixel;
            else
               pixel_expect_q = {pixel_expect_q,
                                 blend_pixel(int'(req_sample_x), int'(req_sample_y))};
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_MAX) begin
         $display("bilinear_rgba_scaler verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_load(int x, int y, logic [PIXEL_W-1:0] px);
      scaler_req_type r;
      r.kind = brs_pkg::REQ_LOAD;
      r.lx = COORD_W'(x);
      r.ly = COORD_W'(y);
      r.pixel = px;
      r.sx = SAMPLE_W'($urandom);
      r.sy = SAMPLE_W'($urandom);
      written_map[y*SRC_SIDE + x] = 1'b1;
      pending_q = {pending_q, r};
      queued_items++;
   endtask

   // loads any unwritten neighbor first, then queues the sample
   task automatic push_sample(int ox, int oy);
      int x0, x1, y0, y1;
      longint unsigned f;
      scaler_req_type r;
      axis_neighbors(ox, gen_sw, gen_tw, x0, x1, f);
      axis_neighbors(oy, gen_sh, gen_th, y0, y1, f);
      if (!written_map[y0*SRC_SIDE + x0]) push_load(x0, y0, pick_pixel());
      if (!written_map[y0*SRC_SIDE + x1]) push_load(x1, y0, pick_pixel());
      if (!written_map[y1*SRC_SIDE + x0]) push_load(x0, y1, pick_pixel());
      if (!written_map[y1*SRC_SIDE + x1]) push_load(x1, y1, pick_pixel());
      r.kind = brs_pkg::REQ_SAMPLE;
      r.lx = COORD_W'($urandom);
      r.ly = COORD_W'($urandom);
      r.pixel = PIXEL_W'($urandom);
      r.sx = SAMPLE_W'(ox);
      r.sy = SAMPLE_W'(oy);
      pending_q = {pending_q, r};
      queued_items++;
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || start || pixel_expect_q.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = CSR_DATA_W'(value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_sizes(int sw, int sh, int tw, int th);
      drain();
      write_reg(brs_pkg::REG_SOURCE_WIDTH, sw);
      write_reg(brs_pkg::REG_SOURCE_HEIGHT, sh);
      write_reg(brs_pkg::REG_TARGET_WIDTH, tw);
      write_reg(brs_pkg::REG_TARGET_HEIGHT, th);
      gen_sw = eff_size(sw, SRC_SIDE);
      gen_sh = eff_size(sh, SRC_SIDE);
      gen_tw = eff_size(tw, TGT_SIDE);
      gen_th = eff_size(th, TGT_SIDE);
   endtask

   // count includes the loads that samples pull in
   task automatic random_items(int count);
      int ox, oy, stop;
      stop = queued_items + count;
      while (queued_items < stop) begin
         if ($urandom_range(99) < 20) begin
            push_load($urandom_range(255), $urandom_range(255), pick_pixel());
         end else begin
            ox = ($urandom_range(9) < 7) ? $urandom_range(gen_tw - 1) : $urandom_range(4095);
            oy = ($urandom_range(9) < 7) ? $urandom_range(gen_th - 1) : $urandom_range(4095);
            push_sample(ox, oy);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: small upscale with extreme pixels and corner samples
      idle_pct = 0;
      set_sizes(4, 3, 8, 6);
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 4; x++)
            push_load(x, y, ((x + y) % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
      push_load(255, 255, 32'hA5C3_0F81);
      push_sample(0, 0);
      push_sample(7, 5);
      push_sample(3, 2);
      push_sample(4095, 4095);
      push_sample(0, 4095);
      push_sample(4095, 0);
      push_sample(1, 1);
      push_sample(6, 4);

      random_items(120);

      idle_pct = 57;
      set_sizes(256, 256, 4096, 4096);
      push_sample(4095, 4095);
      push_sample(0, 0);
      random_items(PHASE_ITEMS);

      idle_pct = 57;
      set_sizes(0, 0, 0, 0);
      random_items(PHASE_ITEMS);

      idle_pct = 14;
      set_sizes(511, 300, 8191, 5000);
      random_items(PHASE_ITEMS);

      idle_pct = 0;
      set_sizes(200, 7, 3, 100);
      random_items(PHASE_ITEMS);

      idle_pct = 57;
      set_sizes(17, 33, 1, 4096);
      random_items(PHASE_ITEMS);

      idle_pct = 14;
      set_sizes($urandom_range(1, 256), $urandom_range(1, 256),
                $urandom_range(1, 4096), $urandom_range(1, 4096));
      random_items(PHASE_ITEMS);

      drain();
      if (mismatches == 0)
         $display("bilinear_rgba_scaler verification clean");
      else
         $display("bilinear_rgba_scaler verification failed");
      $finish;
   end

endmodule
